FILE: src/sequence_reorder_buffer_top_macros.svh
// ----------------------------------------------------------------------------
// Sequence reorder buffer assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef SEQUENCE_REORDER_BUFFER_TOP_MACROS_SVH
`define SEQUENCE_REORDER_BUFFER_TOP_MACROS_SVH

// same-cycle implication
`define SRB_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("srb assertion failed");

// next-cycle implication
`define SRB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("srb assertion failed");

`endif

FILE: src/srb_pkg.sv
// ----------------------------------------------------------------------------
// Sequence reorder buffer package
// Shared constants, codes and types.
// ----------------------------------------------------------------------------
package srb_pkg;

    localparam int DEPTH        = 32;
    localparam int IDX_W        = $clog2(DEPTH);
    localparam int MAX_RESULTS  = 32;
    localparam int CNT_W        = $clog2(MAX_RESULTS + 1);
    localparam int SPAN_W       = 6;
    localparam int ENTRY_W      = 48;

    localparam logic [15:0]       HEADER_BYTES = 16'd6;
    localparam logic [SPAN_W-1:0] SPAN_RESET   = 6'd32;

    typedef enum logic [2:0] {
        ST_DELIVERED = 3'd0,
        ST_HELD      = 3'd1,
        ST_STALE     = 3'd2,
        ST_DUPLICATE = 3'd3,
        ST_BEYOND    = 3'd4,
        ST_SHORT     = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_WALK,
        S_READ
    } state_t;

    typedef struct packed {
        status_t          code;
        logic             accepted;
        logic             expected;
        logic [IDX_W-1:0] idx;
        logic [15:0]      len;
    } class_t;

endpackage

FILE: src/srb_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module srb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/srb_classify.sv
// ----------------------------------------------------------------------------
// Sequence reorder buffer classifier
// Length clip, window distance, slot index and accept/reject decision.
// ----------------------------------------------------------------------------
module srb_classify (
    input  logic [15:0]                  sequence_req,
    input  logic [15:0]                  declared_length,
    input  logic [15:0]                  frame_length,
    input  logic [15:0]                  next_expected,
    input  logic [srb_pkg::IDX_W-1:0]    next_idx,
    input  logic [srb_pkg::SPAN_W-1:0]   accept_span,
    input  logic [srb_pkg::DEPTH-1:0]    slot_valid,
    output srb_pkg::class_t              cls
);

    logic [15:0]               avail;
    logic [15:0]               fwd_gap;
    logic [15:0]               span;
    logic [15:0]               span_raw;
    logic [srb_pkg::IDX_W:0]   idx_sum;
    logic [srb_pkg::IDX_W-1:0] idx;

    always_comb
    begin
        avail    = frame_length - srb_pkg::HEADER_BYTES;
        fwd_gap  = sequence_req - next_expected;
        span_raw = {{(16 - srb_pkg::SPAN_W){1'b0}}, accept_span};

        priority if (span_raw == 16'd0)
        begin
            span = 16'd1;
        end
        else if (span_raw > 16'(srb_pkg::DEPTH))
        begin
            span = 16'(srb_pkg::DEPTH);
        end
        else
        begin
            span = span_raw;
        end

        idx_sum = {1'b0, next_idx} + {1'b0, fwd_gap[srb_pkg::IDX_W-1:0]};
        if (idx_sum >= (srb_pkg::IDX_W + 1)'(srb_pkg::DEPTH))
        begin
            idx_sum = idx_sum - (srb_pkg::IDX_W + 1)'(srb_pkg::DEPTH);
        end
        idx = idx_sum[srb_pkg::IDX_W-1:0];

        cls.idx      = idx;
        cls.len      = (declared_length > avail) ? avail : declared_length;
        cls.expected = (fwd_gap == 16'd0);
        cls.accepted = 1'b0;

        priority if (frame_length < srb_pkg::HEADER_BYTES)
        begin
            cls.code = srb_pkg::ST_SHORT;
        end
        else if (fwd_gap[15])
        begin
            cls.code = srb_pkg::ST_STALE;
        end
        else if (fwd_gap >= span)
        begin
            cls.code = srb_pkg::ST_BEYOND;
        end
        else if (slot_valid[idx])
        begin
            cls.code = srb_pkg::ST_DUPLICATE;
        end
        else
        begin
            cls.code     = cls.expected ? srb_pkg::ST_DELIVERED : srb_pkg::ST_HELD;
            cls.accepted = 1'b1;
        end
    end

endmodule

FILE: src/sequence_reorder_buffer_top.sv
// ----------------------------------------------------------------------------
// Sequence reorder buffer
// Receive-side reorder of sequenced message headers with in-order release.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) takes one message header per transfer.
// Output channel (out_valid/out_ready) gives one result per transfer; the
// final result caused by a header carries last. A rejected header (short,
// stale, beyond window, duplicate) gives one result. An accepted header gives
// a held result when it is not the expected sequence, then one delivered
// result per contiguous slot released, at most 32 per header.
// A header is captured in S_IDLE, then classified and stored in S_CHECK;
// each delivered slot then passes S_WALK (slot RAM read) and S_READ.
// S_READ and a result from S_CHECK wait for a free output register; in_ready is high only between items.
// The output register frees the sequencer: a new header may be taken while
// the last result still waits. If the receiver stalls, the sequencer waits
// with the next result and the output holds steady.
// Reset clears all slot valid marks, the expected sequence and sets
// accept_span to 32; slot contents need no clearing.
// cfg_wr_en/cfg_wr_data write accept_span; write only while idle.
// ----------------------------------------------------------------------------
module sequence_reorder_buffer_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [srb_pkg::SPAN_W-1:0]  cfg_wr_data,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [15:0]                 message_type,
    input  logic [15:0]                 sequence_req,
    input  logic [15:0]                 declared_length,
    input  logic [15:0]                 frame_length,
    input  logic [15:0]                 payload_tag,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [2:0]                  status,
    output logic [15:0]                 out_sequence,
    output logic [15:0]                 out_type,
    output logic [15:0]                 out_tag,
    output logic [15:0]                 out_length,
    output logic                        last
);

    srb_pkg::state_t            state_reg, state_next;
    logic [srb_pkg::SPAN_W-1:0] span_reg;
    logic [15:0]                ne_reg, ne_next;
    logic [srb_pkg::IDX_W-1:0]  ne_idx_reg, ne_idx_next, ne_idx_inc;
    logic [srb_pkg::DEPTH-1:0]  valid_reg, valid_next;
    logic [srb_pkg::CNT_W-1:0]  cnt_reg, cnt_next, cnt_inc;

    logic [15:0] type_reg, type_next;
    logic [15:0] seq_reg, seq_next;
    logic [15:0] decl_reg, decl_next;
    logic [15:0] flen_reg, flen_next;
    logic [15:0] tag_reg, tag_next;

    logic             out_valid_reg, out_valid_next;
    srb_pkg::status_t status_reg, status_next;
    logic [15:0]      oseq_reg, oseq_next;
    logic [15:0]      otype_reg, otype_next;
    logic [15:0]      otag_reg, otag_next;
    logic [15:0]      olen_reg, olen_next;
    logic             last_reg, last_next;

    srb_pkg::class_t             cls;
    logic                        out_free;
    logic                        ram_we;
    logic [srb_pkg::ENTRY_W-1:0] ram_rdata;
    logic                        done;

    srb_classify u_classify (
        .sequence_req    (seq_reg),
        .declared_length (decl_reg),
        .frame_length    (flen_reg),
        .next_expected   (ne_reg),
        .next_idx        (ne_idx_reg),
        .accept_span     (span_reg),
        .slot_valid      (valid_reg),
        .cls             (cls)
    );

    srb_ram #(
        .WIDTH (srb_pkg::ENTRY_W),
        .DEPTH (srb_pkg::DEPTH)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (cls.idx),
        .wdata ({type_reg, tag_reg, cls.len}),
        .raddr (ne_idx_reg),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= srb_pkg::S_IDLE;
            span_reg      <= srb_pkg::SPAN_RESET;
            ne_reg        <= '0;
            ne_idx_reg    <= '0;
            valid_reg     <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ne_reg        <= ne_next;
            ne_idx_reg    <= ne_idx_next;
            valid_reg     <= valid_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                span_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        type_reg   <= type_next;
        seq_reg    <= seq_next;
        decl_reg   <= decl_next;
        flen_reg   <= flen_next;
        tag_reg    <= tag_next;
        status_reg <= status_next;
        oseq_reg   <= oseq_next;
        otype_reg  <= otype_next;
        otag_reg   <= otag_next;
        olen_reg   <= olen_next;
        last_reg   <= last_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        ne_next        = ne_reg;
        ne_idx_next    = ne_idx_reg;
        valid_next     = valid_reg;
        cnt_next       = cnt_reg;
        type_next      = type_reg;
        seq_next       = seq_reg;
        decl_next      = decl_reg;
        flen_next      = flen_reg;
        tag_next       = tag_reg;
        status_next    = status_reg;
        oseq_next      = oseq_reg;
        otype_next     = otype_reg;
        otag_next      = otag_reg;
        olen_next      = olen_reg;
        last_next      = last_reg;
        ram_we         = 1'b0;
        done           = 1'b0;
        out_free       = !out_valid_reg || out_ready;
        out_valid_next = out_valid_reg && !out_ready;
        in_ready       = (state_reg == srb_pkg::S_IDLE);
        cnt_inc        = cnt_reg + srb_pkg::CNT_W'(1);

        // slot index of the sequence after the expected one
        priority if (ne_reg == 16'hFFFF)
        begin
            ne_idx_inc = '0;
        end
        else if (ne_idx_reg == srb_pkg::IDX_W'(srb_pkg::DEPTH - 1))
        begin
            ne_idx_inc = '0;
        end
        else
        begin
            ne_idx_inc = ne_idx_reg + srb_pkg::IDX_W'(1);
        end

        unique case (state_reg)
            srb_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    type_next  = message_type;
                    seq_next   = sequence_req;
                    decl_next  = declared_length;
                    flen_next  = frame_length;
                    tag_next   = payload_tag;
                    state_next = srb_pkg::S_CHECK;
                end
            end
            srb_pkg::S_CHECK:
            begin
                if (cls.accepted && cls.expected)
                begin
                    ram_we              = 1'b1;
                    valid_next[cls.idx] = 1'b1;
                    cnt_next            = '0;
                    state_next          = srb_pkg::S_WALK;
                end
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = cls.code;
                    oseq_next      = seq_reg;
                    if (cls.accepted)
                    begin
                        ram_we              = 1'b1;
                        valid_next[cls.idx] = 1'b1;
                        otype_next          = type_reg;
                        otag_next           = tag_reg;
                        olen_next           = cls.len;
                        cnt_next            = srb_pkg::CNT_W'(1);
                        done                = !valid_reg[ne_idx_reg]
                                              || (srb_pkg::MAX_RESULTS == 1);
                        last_next           = done;
                        state_next          = done ? srb_pkg::S_IDLE : srb_pkg::S_WALK;
                    end
                    else
                    begin
                        otype_next = '0;
                        otag_next  = '0;
                        olen_next  = '0;
                        last_next  = 1'b1;
                        state_next = srb_pkg::S_IDLE;
                    end
                end
            end
            srb_pkg::S_WALK:
            begin
                state_next = srb_pkg::S_READ;
            end
            srb_pkg::S_READ:
            begin
                if (out_free)
                begin
                    out_valid_next         = 1'b1;
                    status_next            = srb_pkg::ST_DELIVERED;
                    oseq_next              = ne_reg;
                    otype_next             = ram_rdata[47:32];
                    otag_next              = ram_rdata[31:16];
                    olen_next              = ram_rdata[15:0];
                    valid_next[ne_idx_reg] = 1'b0;
                    ne_next                = ne_reg + 16'd1;
                    ne_idx_next            = ne_idx_inc;
                    cnt_next               = cnt_inc;
                    done                   = !valid_reg[ne_idx_inc]
                                             || (cnt_inc == srb_pkg::CNT_W'(srb_pkg::MAX_RESULTS));
                    last_next              = done;
                    state_next             = done ? srb_pkg::S_IDLE : srb_pkg::S_WALK;
                end
            end
            default:
            begin
                state_next = srb_pkg::S_IDLE;
            end
        endcase
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign out_sequence = oseq_reg;
    assign out_type     = otype_reg;
    assign out_tag      = otag_reg;
    assign out_length   = olen_reg;
    assign last         = last_reg;

endmodule

FILE: src/srb_checker.sv
// ----------------------------------------------------------------------------
// Sequence reorder buffer checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`include "sequence_reorder_buffer_top_macros.svh"

module srb_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  status,
    input logic [15:0] out_sequence,
    input logic [15:0] out_type,
    input logic [15:0] out_tag,
    input logic [15:0] out_length,
    input logic        last
);

    // stalled result holds
    `SRB_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(status) && $stable(out_sequence) && $stable(out_type) && $stable(out_tag) && $stable(out_length) && $stable(last))

    // rejections are single results
    `SRB_ASSERT_IMPL(a_reject_last, clk, rst_n, out_valid && (status != srb_pkg::ST_DELIVERED) && (status != srb_pkg::ST_HELD), last)

    // busy after an input transfer
    `SRB_ASSERT_NEXT(a_busy_after_in, clk, rst_n, in_valid && in_ready, !in_ready)

    // no new input while a run is still being released
    `SRB_ASSERT_NEXT(a_busy_mid_run, clk, rst_n, out_valid && out_ready && !last, out_valid || !in_ready)

endmodule

bind sequence_reorder_buffer_top srb_checker u_srb_checker (.*);
